/* hdl/slq_pkg.sv */
// ----------------------------------------------------------------------------
// slq_pkg: shared definitions for the sorted list queue
// Sizes, status codes and the per-cell control bundle used by the cell chain.
// ----------------------------------------------------------------------------
package slq_pkg;

    // Number of cells in the chain.
    localparam int CAPACITY  = 16;
    // Width of a stored value.
    localparam int DATA_W    = 32;
    // Width of the fill count, which must hold CAPACITY itself.
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    // Width of the entries field on the result channel.
    localparam int ENTRIES_W = 5;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } slq_status_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic                     insert;
        logic                     pop;
        logic signed [DATA_W-1:0] value;
    } slq_ctrl_t;

endpackage

/* hdl/slq_cell.sv */
// ----------------------------------------------------------------------------
// slq_cell: one storage cell of the sorted chain
// Holds one value, compares it with the broadcast insert value and moves
// data to or from its neighbors on an insert or a pop.
// ----------------------------------------------------------------------------
module slq_cell import slq_pkg::*; (
    input  logic                     aclk,
    input  slq_ctrl_t                ctrl,
    input  logic                     occupied,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic                     left_ge,
    input  logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0] value,
    output logic                     ge
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // The new value belongs at or left of this cell when the cell is free
    // or holds a value greater than or equal to it.
    assign ge    = !occupied || (value_reg >= ctrl.value);
    assign value = value_reg;

    // On insert, cells at and right of the slot shift right and the slot
    // takes the new value. On pop, every cell takes its right neighbor.
    always_comb begin
        value_next = value_reg;
        if (ctrl.insert) begin
            if (left_ge) begin
                value_next = left_value;
            end else if (ge) begin
                value_next = ctrl.value;
            end
        end else if (ctrl.pop) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

/* hdl/sorted_list_queue_top.sv */
// ----------------------------------------------------------------------------
// sorted_list_queue_top: bounded ascending list used as a priority queue
// A chain of cells keeps the values sorted, and every beat yields the
// smallest, largest, count and status.
//
//   channel | direction | payload
//   s_      | in        | action, value
//   m_      | out       | smallest, largest, entries, is_empty, status
//
// All cells compare with the new value in parallel and shift in the same
// edge, so a beat can be taken every cycle unless the result channel stalls.
// The result register frees when its beat is taken, and a new input beat is
// accepted in that same cycle. Reset empties the list.
// ----------------------------------------------------------------------------
module sorted_list_queue_top import slq_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic signed [DATA_W-1:0]    s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_W-1:0]    m_smallest,
    output logic signed [DATA_W-1:0]    m_largest,
    output logic [ENTRIES_W-1:0]        m_entries,
    output logic                        m_is_empty,
    output logic [1:0]                  m_status
);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic signed [DATA_W-1:0] largest_reg;
    logic signed [DATA_W-1:0] largest_next;
    slq_status_t              status_reg;
    slq_status_t              status_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;

    logic                     accept;
    logic                     list_full;
    logic                     list_empty;
    slq_ctrl_t                ctrl;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic                     cell_ge    [CAPACITY];

    // Handshake: the result register parts the two sides.
    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);

    // Control broadcast to the cell chain.
    assign ctrl.insert = accept && !s_action && !list_full;
    assign ctrl.pop    = accept && s_action && !list_empty;
    assign ctrl.value  = s_value;

    // The cell chain.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_value;
        logic                     left_ge;
        logic signed [DATA_W-1:0] right_value;
        logic                     occupied;

        assign occupied = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign left_value = '0;
            assign left_ge    = 1'b0;
        end else begin : g_inner
            assign left_value = cell_value[i-1];
            assign left_ge    = cell_ge[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_body
            assign right_value = cell_value[i+1];
        end

        slq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (occupied),
            .left_value  (left_value),
            .left_ge     (left_ge),
            .right_value (right_value),
            .value       (cell_value[i]),
            .ge          (cell_ge[i])
        );
    end

    // Count, largest value and status for the accepted beat.
    always_comb begin
        count_next   = count_reg;
        largest_next = largest_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = ST_DONE;
            if (!s_action) begin
                if (list_full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (list_empty || (s_value > largest_reg)) begin
                        largest_next = s_value;
                    end
                end
            end else begin
                if (list_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            status_reg  <= ST_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
        largest_reg <= largest_next;
    end

    // Result beat, read straight from the state that only moves on accept.
    assign m_valid    = m_valid_reg;
    assign m_is_empty = list_empty;
    assign m_smallest = list_empty ? '0 : cell_value[0];
    assign m_largest  = list_empty ? '0 : largest_reg;
    assign m_status   = status_reg;

    if (CNT_W >= ENTRIES_W) begin : g_entries_trunc
        assign m_entries = count_reg[ENTRIES_W-1:0];
    end else begin : g_entries_ext
        assign m_entries = {{(ENTRIES_W - CNT_W){1'b0}}, count_reg};
    end

endmodule

/* hdl/slq_checker.sv */
// ----------------------------------------------------------------------------
// slq_checker: port-level checks for the sorted list queue
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module slq_checker import slq_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     s_action,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_smallest,
    input logic signed [DATA_W-1:0] m_largest,
    input logic [ENTRIES_W-1:0]     m_entries,
    input logic                     m_is_empty,
    input logic [1:0]               m_status
);

    // A stalled result beat holds its smallest, largest and status.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_smallest) && $stable(m_largest)
            && $stable(m_status))
        else $error("result beat changed while stalled");

    // The list never holds its smallest value above its largest.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_empty |-> m_smallest <= m_largest)
        else $error("smallest above largest");

    // An empty list reports zero values.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_smallest == '0 && m_largest == '0)
        else $error("empty list reports nonzero values");

    // A rejected pop only happens on an empty list.
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_is_empty)
        else $error("pop rejected on a list that is not empty");

    // A pop on a list of one entry empties it.
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action && m_valid && m_entries == ENTRIES_W'(1)
            |=> m_is_empty)
        else $error("pop of the last entry left the list nonempty");

endmodule

bind sorted_list_queue_top slq_checker u_slq_checker (.*);
